// ===== hdl/chmm_pkg.sv =====
// ============================================================================
// Compass heading package
// Shared types, command and register codes, fixed-point constants and the
// arctangent table used by the min/max calibrated compass heading block.
// ============================================================================
`default_nettype none

package chmm_pkg;

    // Number of CORDIC vectoring rotations (12 to 24)
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

    // Arctangent table geometry
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 22;

    // Angle accumulator in signed Q8.16 degrees (sign, 8 integer and 16 fraction bits)
    localparam int Z_W = 25;
    localparam logic signed [Z_W-1:0] QUARTER_Q16 = 25'sd5898240;   // 90 degrees
    localparam logic [23:0]           HALF_Q16    = 24'd11796480;   // 180 degrees

    // Full circle in whole degrees
    localparam logic [8:0] FULL_DEG = 9'd360;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_X_HIGH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_HIGH = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_LOW  = 2'd3;

    // Commands carried with each sample
    typedef enum logic [1:0] {
        CMD_HEADING = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_LOAD    = 2'd3
    } cmd_t;

    // Input word
    typedef struct packed {
        cmd_t               command;
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
    } sample_t;

    // Result word
    typedef struct packed {
        logic [8:0]         heading_deg;
        logic               heading_valid;
        logic signed [15:0] x_high_out;
        logic signed [15:0] x_low_out;
        logic signed [15:0] y_high_out;
        logic signed [15:0] y_low_out;
    } result_t;

    // atan(2^-i) in degrees, unsigned Q6.16, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/compass_heading_min_max_calibration.sv =====
// ============================================================================
// Compass heading with min/max calibration
// Keeps hard-iron min/max bounds per axis and turns each X/Y sample into a
// whole-degree heading with a shared multiplier and an iterative CORDIC.
// ============================================================================
// A heading command passes through these steps from acceptance to the
// result word: recentring the sample, the X and Y products on the single
// 16x16 multiplier that scales both axes, five normalising shift steps, one
// CORDIC rotation per cycle, folding the angle into degrees and loading the
// output register once it is free. The next word can be accepted when the
// result is loaded and the sequencer is back in idle. Clear, load and
// zero-span words skip the arithmetic and go from recentring straight to
// the output register; on-axis samples skip the normalisation and the
// rotations. One word is in work at a time; a finished word waits in the
// output register while the next is accepted.
`default_nettype none

module compass_heading_min_max_calibration (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire chmm_pkg::sample_t              s_data,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      chmm_pkg::result_t              m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [chmm_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MULX,
        ST_MULY,
        ST_NORM,
        ST_ROT,
        ST_RESOLVE,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    chmm_pkg::cmd_t                   cmd_reg;
    logic signed [15:0]               xs_reg, ys_reg;
    logic signed [15:0]               x_high_bound_reg, x_low_bound_reg;
    logic signed [15:0]               y_high_bound_reg, y_low_bound_reg;
    logic signed [15:0]               saved_x_high_reg, saved_x_low_reg;
    logic signed [15:0]               saved_y_high_reg, saved_y_low_reg;
    logic [15:0]                      axr_reg, ayr_reg, aspx_reg, aspy_reg;
    logic                             xneg_reg, yneg_reg, xzero_reg, yzero_reg;
    logic signed [33:0]               cx_reg, cy_reg;
    logic signed [chmm_pkg::Z_W-1:0]  z_reg;
    logic [chmm_pkg::ITER_W-1:0]      iter_reg;
    logic [2:0]                       norm_reg;
    logic [8:0]                       deg_reg;
    logic                             hvalid_reg;
    logic                             m_valid_reg;
    chmm_pkg::result_t                out_reg;

    // Recentring and span terms, from the bounds and the held sample
    logic signed [16:0] spx, spy, sumx, sumy, meanx, meany;
    logic [15:0]        xr, yr, axr, ayr, aspx_abs, aspy_abs;
    logic [16:0]        spx_neg, spy_neg;
    logic               zero_span;

    always_comb begin
        spx     = {x_high_bound_reg[15], x_high_bound_reg} - {x_low_bound_reg[15], x_low_bound_reg};
        spy     = {y_high_bound_reg[15], y_high_bound_reg} - {y_low_bound_reg[15], y_low_bound_reg};
        sumx    = {x_high_bound_reg[15], x_high_bound_reg} + {x_low_bound_reg[15], x_low_bound_reg};
        sumy    = {y_high_bound_reg[15], y_high_bound_reg} + {y_low_bound_reg[15], y_low_bound_reg};
        // Halve with truncation toward zero
        meanx   = (sumx + $signed({16'd0, sumx[16]})) >>> 1;
        meany   = (sumy + $signed({16'd0, sumy[16]})) >>> 1;
        xr      = xs_reg - meanx[15:0];
        yr      = ys_reg - meany[15:0];
        axr     = xr[15] ? (16'd0 - xr) : xr;
        ayr     = yr[15] ? (16'd0 - yr) : yr;
        spx_neg = 17'd0 - spx;
        spy_neg = 17'd0 - spy;
        aspx_abs = spx[16] ? spx_neg[15:0] : spx[15:0];
        aspy_abs = spy[16] ? spy_neg[15:0] : spy[15:0];
        zero_span = (spx == 17'sd0) || (spy == 17'sd0);
    end

    // Shared multiplier: X magnitude first, then Y magnitude
    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_p;

    always_comb begin
        mul_a = (state_reg == ST_MULX) ? axr_reg : ayr_reg;
        mul_b = (state_reg == ST_MULX) ? aspy_reg : aspx_reg;
        mul_p = mul_a * mul_b;
    end

    // Normalising shift step: 16, 8, 4, 2, then 1 place
    logic [30:0] norm_or;
    logic [4:0]  norm_shift;
    logic        norm_clear;

    always_comb begin
        norm_or    = cx_reg[30:0] | cy_reg[30:0];
        norm_shift = 5'd16 >> norm_reg;
        norm_clear = ((norm_or >> (5'd31 - norm_shift)) == 31'd0);
    end

    // One CORDIC vectoring rotation
    logic signed [33:0]              rot_dx, rot_dy;
    logic                            cy_pos;
    logic signed [chmm_pkg::Z_W-1:0] atan_step;

    always_comb begin
        rot_dx    = cy_reg >>> iter_reg;
        rot_dy    = cx_reg >>> iter_reg;
        cy_pos    = !cy_reg[33] && (cy_reg != 34'sd0);
        atan_step = $signed({3'd0, chmm_pkg::atan_lookup(chmm_pkg::ATAN_IDX_W'(iter_reg))});
    end

    // Fold the first-quadrant angle into whole degrees 1..360
    logic signed [chmm_pkg::Z_W-1:0] z_clamp;
    logic [23:0]                     mag;
    logic [7:0]                      mag_deg;
    logic                            x_nonneg, y_nonneg;
    logic [8:0]                      deg_fold;

    always_comb begin
        if (z_reg < 0) begin
            z_clamp = '0;
        end else if (z_reg > chmm_pkg::QUARTER_Q16) begin
            z_clamp = chmm_pkg::QUARTER_Q16;
        end else begin
            z_clamp = z_reg;
        end
        x_nonneg = xzero_reg || !xneg_reg;
        y_nonneg = yzero_reg || !yneg_reg;
        mag      = x_nonneg ? z_clamp[23:0] : (chmm_pkg::HALF_Q16 - z_clamp[23:0]);
        mag_deg  = mag[23:16];
        if (y_nonneg) begin
            deg_fold = (mag_deg == 8'd0) ? chmm_pkg::FULL_DEG : {1'b0, mag_deg};
        end else begin
            deg_fold = chmm_pkg::FULL_DEG - {1'b0, mag_deg};
        end
    end

    // The finished word moves into the output register once it is free
    logic out_load;

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Sequencer, bounds, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            x_high_bound_reg <= '0;
            x_low_bound_reg  <= '0;
            y_high_bound_reg <= '0;
            y_low_bound_reg  <= '0;
            saved_x_high_reg <= '0;
            saved_x_low_reg  <= '0;
            saved_y_high_reg <= '0;
            saved_y_low_reg  <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    chmm_pkg::REG_X_HIGH: saved_x_high_reg <= cfg_wdata;
                    chmm_pkg::REG_X_LOW:  saved_x_low_reg  <= cfg_wdata;
                    chmm_pkg::REG_Y_HIGH: saved_y_high_reg <= cfg_wdata;
                    chmm_pkg::REG_Y_LOW:  saved_y_low_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= s_data.command;
                        xs_reg    <= s_data.x_sample;
                        ys_reg    <= s_data.y_sample;
                        state_reg <= ST_PREP;
                        case (s_data.command)
                            chmm_pkg::CMD_UPDATE: begin
                                if (s_data.x_sample < x_low_bound_reg)
                                    x_low_bound_reg <= s_data.x_sample;
                                if (s_data.x_sample > x_high_bound_reg)
                                    x_high_bound_reg <= s_data.x_sample;
                                if (s_data.y_sample < y_low_bound_reg)
                                    y_low_bound_reg <= s_data.y_sample;
                                if (s_data.y_sample > y_high_bound_reg)
                                    y_high_bound_reg <= s_data.y_sample;
                            end
                            chmm_pkg::CMD_CLEAR: begin
                                x_high_bound_reg <= '0;
                                x_low_bound_reg  <= '0;
                                y_high_bound_reg <= '0;
                                y_low_bound_reg  <= '0;
                            end
                            chmm_pkg::CMD_LOAD: begin
                                x_high_bound_reg <= saved_x_high_reg;
                                x_low_bound_reg  <= saved_x_low_reg;
                                y_high_bound_reg <= saved_y_high_reg;
                                y_low_bound_reg  <= saved_y_low_reg;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_PREP: begin
                    axr_reg   <= axr;
                    ayr_reg   <= ayr;
                    aspx_reg  <= aspx_abs;
                    aspy_reg  <= aspy_abs;
                    xneg_reg  <= xr[15] ^ spx[16];
                    yneg_reg  <= yr[15] ^ spy[16];
                    xzero_reg <= (xr == 16'd0);
                    yzero_reg <= (yr == 16'd0);
                    if (cmd_reg == chmm_pkg::CMD_CLEAR || cmd_reg == chmm_pkg::CMD_LOAD
                        || zero_span) begin
                        deg_reg    <= 9'd0;
                        hvalid_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg  <= ST_MULX;
                    end
                end

                ST_MULX: begin
                    cx_reg    <= $signed({2'b00, mul_p});
                    state_reg <= ST_MULY;
                end

                ST_MULY: begin
                    cy_reg   <= $signed({2'b00, mul_p});
                    norm_reg <= 3'd0;
                    iter_reg <= '0;
                    // On-axis samples have an exact angle
                    if (yzero_reg) begin
                        z_reg     <= '0;
                        state_reg <= ST_RESOLVE;
                    end else if (xzero_reg) begin
                        z_reg     <= chmm_pkg::QUARTER_Q16;
                        state_reg <= ST_RESOLVE;
                    end else begin
                        z_reg     <= '0;
                        state_reg <= ST_NORM;
                    end
                end

                ST_NORM: begin
                    if (norm_clear) begin
                        cx_reg <= cx_reg <<< norm_shift;
                        cy_reg <= cy_reg <<< norm_shift;
                    end
                    norm_reg <= norm_reg + 3'd1;
                    if (norm_reg == 3'd4) begin
                        state_reg <= ST_ROT;
                    end
                end

                ST_ROT: begin
                    if (cy_pos) begin
                        cx_reg <= cx_reg + rot_dx;
                        cy_reg <= cy_reg - rot_dy;
                        z_reg  <= z_reg + atan_step;
                    end else begin
                        cx_reg <= cx_reg - rot_dx;
                        cy_reg <= cy_reg + rot_dy;
                        z_reg  <= z_reg - atan_step;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == chmm_pkg::ITER_W'(chmm_pkg::CORDIC_ITERATIONS - 1)) begin
                        state_reg <= ST_RESOLVE;
                    end
                end

                ST_RESOLVE: begin
                    deg_reg    <= deg_fold;
                    hvalid_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end

                ST_DONE: begin
                    // Wait for the output register to be free
                    if (out_load) begin
                        out_reg.heading_deg   <= deg_reg;
                        out_reg.heading_valid <= hvalid_reg;
                        out_reg.x_high_out    <= x_high_bound_reg;
                        out_reg.x_low_out     <= x_low_bound_reg;
                        out_reg.y_high_out    <= y_high_bound_reg;
                        out_reg.y_low_out     <= y_low_bound_reg;
                        state_reg             <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A word is worked on alone: no second acceptance straight after one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while busy");

    // A valid heading lies in 1..360, an invalid one reads zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.heading_valid
            ? (m_data.heading_deg >= 9'd1 && m_data.heading_deg <= chmm_pkg::FULL_DEG)
            : (m_data.heading_deg == 9'd0)))
        else $error("heading out of range");

    // A clear command empties all four bounds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.command == chmm_pkg::CMD_CLEAR) |=>
            (x_high_bound_reg == 16'sd0 && x_low_bound_reg == 16'sd0
             && y_high_bound_reg == 16'sd0 && y_low_bound_reg == 16'sd0))
        else $error("bounds not cleared");

    // The bounds only move at acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && $past(state_reg) != ST_IDLE) |->
            ($stable(x_high_bound_reg) && $stable(x_low_bound_reg)
             && $stable(y_high_bound_reg) && $stable(y_low_bound_reg)))
        else $error("bounds changed during a computation");

endmodule

`default_nettype wire
